>>> src/ttm_pkg.sv
// ----------------------------------------------------------------------------
// ttm_pkg
// Types and constants shared by the task timing monitor.
// ----------------------------------------------------------------------------
package ttm_pkg;

  localparam int unsigned TimeW    = 64;
  localparam int unsigned WordW    = 32;
  localparam int unsigned KindW    = 4;
  localparam int unsigned HistBins = 8;
  localparam int unsigned SnapWords = 16;
  localparam int unsigned CfgRegs  = 4;

  typedef enum logic [2:0] {
    ACT_RECORD   = 3'd0,
    ACT_BEGIN    = 3'd1,
    ACT_END      = 3'd2,
    ACT_EVENT    = 3'd3,
    ACT_STACK    = 3'd4,
    ACT_SNAPSHOT = 3'd5,
    ACT_CLEAR    = 3'd6
  } action_e;

  // counter kinds on the snapshot stream
  localparam logic [KindW-1:0] KIND_RUNS   = 4'd0;
  localparam logic [KindW-1:0] KIND_EXEC   = 4'd1;
  localparam logic [KindW-1:0] KIND_GAP    = 4'd2;
  localparam logic [KindW-1:0] KIND_JIT    = 4'd3;
  localparam logic [KindW-1:0] KIND_MISS   = 4'd4;
  localparam logic [KindW-1:0] KIND_STACK  = 4'd5;
  localparam logic [KindW-1:0] KIND_HIST0  = 4'd6;
  localparam logic [KindW-1:0] KIND_EVENT0 = 4'd14;

  typedef struct packed {
    logic [2:0]       action;
    logic [2:0]       task_req;
    logic [TimeW-1:0] scheduled_time;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] finish_time;
    logic [2:0]       event_kind;
    logic [WordW-1:0] stack_words;
  } in_word_t;

  typedef struct packed {
    logic [KindW-1:0] counter_kind;
    logic [WordW-1:0] counter_value;
    logic             last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch input word
    logic calc;      // stage 1 of cycle update: deltas
    logic commit;    // stage 2: write back
    logic clear;     // zero all task state
    logic snap_load; // load snapshot output register with kind snap_kind
    logic [KindW-1:0] snap_kind;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] action;
  } stat_t;

  function automatic logic [WordW-1:0] sat_delta(logic [TimeW-1:0] later,
                                                 logic [TimeW-1:0] earlier);
    logic [TimeW-1:0] d;
    d = later - earlier;
    if (later <= earlier) return '0;
    if (d[TimeW-1:WordW] != '0) return '1;
    return d[WordW-1:0];
  endfunction

  function automatic logic [2:0] bin_of(logic [WordW-1:0] e);
    if (e <= 32'd100)   return 3'd0;
    if (e <= 32'd250)   return 3'd1;
    if (e <= 32'd500)   return 3'd2;
    if (e <= 32'd1000)  return 3'd3;
    if (e <= 32'd2500)  return 3'd4;
    if (e <= 32'd5000)  return 3'd5;
    if (e <= 32'd10000) return 3'd6;
    return 3'd7;
  endfunction

endpackage

>>> src/ttm_if.sv
// ----------------------------------------------------------------------------
// ttm_if
// Valid/ready channel carrying one word of payload type.
// ----------------------------------------------------------------------------
interface ttm_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/task_timing_monitor_core.sv
// ----------------------------------------------------------------------------
// task_timing_monitor_core
// Per-task execution timing monitor.
// ----------------------------------------------------------------------------
// Use: one word on in_ch is one request (record, begin, end, event count,
// set stack, snapshot or clear). Deadlines are written on cfg_ch, register
// index 0..3; other indices are dropped. The user must write them only
// while the block is idle; the block itself does not enforce this. Begin,
// event, stack and clear are written back from the decode state; record and
// end step through capture, decode, delta compute and write back, with the
// deltas registered in front of the counter file write. in_ch.ready is high
// only in the idle state, so one request is handled at a time. Snapshot:
// sixteen words follow on out_ch, one per cycle when the sink is ready,
// counter_kind 0..15, last on the sixteenth; all values zero for an invalid
// task. A stalled sink holds the current word in the output register; the
// sequencer waits and in_ch stays blocked until the last word is taken.
// Reset: all counters, timestamps and deadlines cleared, channels idle.
// ----------------------------------------------------------------------------
module task_timing_monitor_core #(
  parameter int unsigned Tasks      = 4,
  parameter int unsigned EventKinds = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  ttm_if.sink   in_ch,
  ttm_if.sink   cfg_ch,
  ttm_if.source out_ch
);
  import ttm_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // config words are {index[2:0], data[31:0]}
  assign cfg_ch.ready = 1'b1;

  ttm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  ttm_datapath #(.Tasks(Tasks), .EventKinds(EventKinds)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.data),
    .cfg_we_i   (cfg_ch.valid && (cfg_ch.data[34:32] < 3'd4)),
    .cfg_idx_i  (cfg_ch.data[33:32]),
    .cfg_data_i (cfg_ch.data[31:0]),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .out_o      (out_ch.data)
  );
endmodule

>>> src/ttm_ctrl.sv
// ----------------------------------------------------------------------------
// ttm_ctrl
// Sequencer: accepts a word, steps the datapath, streams snapshot words.
// ----------------------------------------------------------------------------
module ttm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  ttm_pkg::stat_t stat_i,
  output ttm_pkg::ctrl_t ctrl_o
);
  import ttm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_CALC, S_COMMIT, S_SNAP} state_e;

  state_e           state_q, state_d;
  logic [KindW-1:0] kind_q, kind_d;
  logic             ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    ovalid_d = ovalid_q;
    ctrl_o   = '0;
    ctrl_o.snap_kind = kind_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.action)
          ACT_RECORD, ACT_END: state_d = S_CALC;
          ACT_SNAPSHOT: begin
            kind_d = '0;
            state_d = S_SNAP;
          end
          ACT_BEGIN, ACT_EVENT, ACT_STACK, ACT_CLEAR: begin
            ctrl_o.commit = (stat_i.action != ACT_CLEAR);
            ctrl_o.clear  = (stat_i.action == ACT_CLEAR);
            state_d = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_CALC: begin
        ctrl_o.calc = 1'b1;
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        ctrl_o.commit = 1'b1;
        state_d = S_IDLE;
      end
      S_SNAP: begin
        if (!ovalid_q || out_ready_i) begin
          if (ovalid_q && kind_q == '0) begin
            // final word just taken
            ovalid_d = 1'b0;
            state_d  = S_IDLE;
          end else begin
            ctrl_o.snap_load = 1'b1;
            ovalid_d = 1'b1;
            kind_d   = kind_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule

>>> src/ttm_datapath.sv
// ----------------------------------------------------------------------------
// ttm_datapath
// Per-task counter file, delta units and snapshot output register.
// ----------------------------------------------------------------------------
module ttm_datapath #(
  parameter int unsigned Tasks      = 4,
  parameter int unsigned EventKinds = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ttm_pkg::in_word_t      in_i,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [ttm_pkg::WordW-1:0] cfg_data_i,
  input  ttm_pkg::ctrl_t         ctrl_i,
  output ttm_pkg::stat_t         stat_o,
  output ttm_pkg::out_word_t     out_o
);
  import ttm_pkg::*;

  localparam int unsigned TW = (Tasks > 1) ? $clog2(Tasks) : 1;
  localparam int unsigned EW = (EventKinds > 1) ? $clog2(EventKinds) : 1;

  in_word_t         req_q;
  logic [WordW-1:0] dl_q [CfgRegs];

  logic [WordW-1:0] runs_q  [Tasks];
  logic [WordW-1:0] mexec_q [Tasks];
  logic [WordW-1:0] mgap_q  [Tasks];
  logic [WordW-1:0] mjit_q  [Tasks];
  logic [WordW-1:0] miss_q  [Tasks];
  logic [WordW-1:0] stack_q [Tasks];
  logic [WordW-1:0] hist_q  [Tasks][HistBins];
  logic [WordW-1:0] evt_q   [Tasks][EventKinds];
  logic [TimeW-1:0] psched_q[Tasks];
  logic [TimeW-1:0] pstart_q[Tasks];
  logic [TimeW-1:0] prev_q  [Tasks];
  logic             havep_q [Tasks];

  // stage-1 results
  logic [WordW-1:0] exec_q, jit_q, gap_q;
  logic             miss_q1;
  logic [TimeW-1:0] st_q;

  logic             tvalid;
  logic [TW-1:0]    t;
  logic [TimeW-1:0] sched, start;
  logic [WordW-1:0] dl;
  logic [TimeW-1:0] fs;
  out_word_t        out_q;

  assign tvalid = ({29'd0, req_q.task_req} < Tasks);
  assign t      = req_q.task_req[TW-1:0];
  assign sched  = (req_q.action == ACT_END) ? psched_q[t] : req_q.scheduled_time;
  assign start  = (req_q.action == ACT_END) ? pstart_q[t] : req_q.start_time;
  assign dl     = dl_q[req_q.task_req[1:0]];
  assign fs     = req_q.finish_time - sched;
  assign stat_o.action = req_q.action;
  assign out_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) req_q <= in_i;
    if (ctrl_i.calc) begin
      exec_q  <= sat_delta(req_q.finish_time, start);
      jit_q   <= (start >= sched) ? sat_delta(start, sched) : sat_delta(sched, start);
      gap_q   <= sat_delta(start, prev_q[t]);
      miss_q1 <= (dl != '0) && (req_q.finish_time > sched) && (fs > {32'd0, dl});
      st_q    <= start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CfgRegs; i++) dl_q[i] <= '0;
    end else if (cfg_we_i) begin
      dl_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Tasks; i++) begin
        runs_q[i] <= '0; mexec_q[i] <= '0; mgap_q[i] <= '0; mjit_q[i] <= '0;
        miss_q[i] <= '0; stack_q[i] <= '0; psched_q[i] <= '0; pstart_q[i] <= '0;
        prev_q[i] <= '0; havep_q[i] <= 1'b0;
        for (int b = 0; b < HistBins; b++) hist_q[i][b] <= '0;
        for (int e = 0; e < EventKinds; e++) evt_q[i][e] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < Tasks; i++) begin
        runs_q[i] <= '0; mexec_q[i] <= '0; mgap_q[i] <= '0; mjit_q[i] <= '0;
        miss_q[i] <= '0; stack_q[i] <= '0; psched_q[i] <= '0; pstart_q[i] <= '0;
        prev_q[i] <= '0; havep_q[i] <= 1'b0;
        for (int b = 0; b < HistBins; b++) hist_q[i][b] <= '0;
        for (int e = 0; e < EventKinds; e++) evt_q[i][e] <= '0;
      end
    end else if (ctrl_i.commit && tvalid) begin
      case (req_q.action)
        ACT_RECORD, ACT_END: begin
          runs_q[t] <= runs_q[t] + 1'b1;
          if (exec_q > mexec_q[t]) mexec_q[t] <= exec_q;
          if (jit_q > mjit_q[t]) mjit_q[t] <= jit_q;
          hist_q[t][bin_of(exec_q)] <= hist_q[t][bin_of(exec_q)] + 1'b1;
          if (havep_q[t] && gap_q > mgap_q[t]) mgap_q[t] <= gap_q;
          prev_q[t]  <= st_q;
          havep_q[t] <= 1'b1;
          if (miss_q1) miss_q[t] <= miss_q[t] + 1'b1;
        end
        ACT_BEGIN: begin
          psched_q[t] <= req_q.scheduled_time;
          pstart_q[t] <= req_q.start_time;
        end
        ACT_EVENT: begin
          if ({29'd0, req_q.event_kind} < EventKinds)
            evt_q[t][req_q.event_kind[EW-1:0]] <= evt_q[t][req_q.event_kind[EW-1:0]] + 1'b1;
        end
        ACT_STACK: stack_q[t] <= req_q.stack_words;
        default: ;
      endcase
    end
  end

  // snapshot word select
  logic [WordW-1:0] snap_val;
  always_comb begin
    snap_val = '0;
    if (tvalid) begin
      case (ctrl_i.snap_kind)
        KIND_RUNS:  snap_val = runs_q[t];
        KIND_EXEC:  snap_val = mexec_q[t];
        KIND_GAP:   snap_val = mgap_q[t];
        KIND_JIT:   snap_val = mjit_q[t];
        KIND_MISS:  snap_val = miss_q[t];
        KIND_STACK: snap_val = stack_q[t];
        default: begin
          if (ctrl_i.snap_kind >= KIND_EVENT0) begin
            if ({28'd0, ctrl_i.snap_kind - KIND_EVENT0} < EventKinds)
              snap_val = evt_q[t][EW'(ctrl_i.snap_kind - KIND_EVENT0)];
          end else begin
            snap_val = hist_q[t][3'(ctrl_i.snap_kind - KIND_HIST0)];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.snap_load) begin
      out_q.counter_kind  <= ctrl_i.snap_kind;
      out_q.counter_value <= snap_val;
      out_q.last          <= (ctrl_i.snap_kind == KindW'(SnapWords - 1));
    end
  end
endmodule

>>> verif/ttm_checker.sv
// ----------------------------------------------------------------------------
// ttm_checker
// Watches the request, deadline and snapshot channels of the timing monitor,
// keeps its own copy of the per-task counters and compares every snapshot
// word with the value that copy gives.
// ----------------------------------------------------------------------------
module ttm_checker
  import ttm_pkg::*;
#(
  parameter int unsigned Tasks      = 4,
  parameter int unsigned EventKinds = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_word_t         in_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [WordW-1:0] cfg_value_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_word_t        out_data_i,
  output int unsigned      errors_o,
  output int unsigned      waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [WordW-1:0] runs_q     [Tasks];
  logic [WordW-1:0] exec_max_q [Tasks];
  logic [WordW-1:0] gap_max_q  [Tasks];
  logic [WordW-1:0] jit_max_q  [Tasks];
  logic [WordW-1:0] misses_q   [Tasks];
  logic [WordW-1:0] stack_q    [Tasks];
  logic [WordW-1:0] hist_q     [Tasks][HistBins];
  logic [WordW-1:0] events_q   [Tasks][8];
  logic [TimeW-1:0] pend_sched_q [Tasks];
  logic [TimeW-1:0] pend_start_q [Tasks];
  logic [TimeW-1:0] prev_start_q [Tasks];
  logic             has_prev_q [Tasks];
  logic [WordW-1:0] deadline_q [CfgRegs];

  out_word_t snap_words_q[$];

  function automatic logic [WordW-1:0] clipped_diff(logic [TimeW-1:0] hi, logic [TimeW-1:0] lo);
    logic [TimeW-1:0] diff;
    diff = hi - lo;
    if (hi <= lo) return '0;
    if (diff > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return diff[WordW-1:0];
  endfunction

  function automatic int unsigned exec_bin(logic [WordW-1:0] e);
    int unsigned limits[7] = '{100, 250, 500, 1000, 2500, 5000, 10000};
    for (int i = 0; i < 7; i++)
      if (e <= limits[i]) return i;
    return 7;
  endfunction

  function automatic logic [WordW-1:0] counter_of(int unsigned t, int unsigned k);
    if (k == 0) return runs_q[t];
    if (k == 1) return exec_max_q[t];
    if (k == 2) return gap_max_q[t];
    if (k == 3) return jit_max_q[t];
    if (k == 4) return misses_q[t];
    if (k == 5) return stack_q[t];
    if (k < 14) return hist_q[t][k-6];
    if (k - 14 < EventKinds) return events_q[t][k-14];
    return '0;
  endfunction

  task automatic wipe_counters();
    for (int t = 0; t < Tasks; t++) begin
      runs_q[t] = '0; exec_max_q[t] = '0; gap_max_q[t] = '0; jit_max_q[t] = '0;
      misses_q[t] = '0; stack_q[t] = '0; pend_sched_q[t] = '0; pend_start_q[t] = '0;
      prev_start_q[t] = '0; has_prev_q[t] = 1'b0;
      for (int b = 0; b < HistBins; b++) hist_q[t][b] = '0;
      for (int e = 0; e < 8; e++) events_q[t][e] = '0;
    end
  endtask

  task automatic account_cycle(int unsigned t, logic [TimeW-1:0] sched,
                               logic [TimeW-1:0] start, logic [TimeW-1:0] finish);
    logic [WordW-1:0] ex;
    logic [WordW-1:0] jt;
    logic [WordW-1:0] gp;
    ex = clipped_diff(finish, start);
    jt = (start >= sched) ? clipped_diff(start, sched) : clipped_diff(sched, start);
    runs_q[t] = runs_q[t] + 1;
    if (ex > exec_max_q[t]) exec_max_q[t] = ex;
    if (jt > jit_max_q[t]) jit_max_q[t] = jt;
    hist_q[t][exec_bin(ex)] = hist_q[t][exec_bin(ex)] + 1;
    if (has_prev_q[t]) begin
      gp = clipped_diff(start, prev_start_q[t]);
      if (gp > gap_max_q[t]) gap_max_q[t] = gp;
    end
    prev_start_q[t] = start;
    has_prev_q[t] = 1'b1;
    if (deadline_q[t] != 0 && finish > sched && (finish - sched) > {32'd0, deadline_q[t]})
      misses_q[t] = misses_q[t] + 1;
  endtask

  task automatic report(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
    $display("[%0t] ttm_checker: %s got %0h want %0h", $time, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned t;
    out_word_t w;
    out_word_t want;
    if (!rst_ni) begin
      wipe_counters();
      for (int i = 0; i < CfgRegs; i++) deadline_q[i] = '0;
      snap_words_q.delete();
      waiting_o = 0;
      errors_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < CfgRegs)
        deadline_q[cfg_index_i] = cfg_value_i;
      if (out_valid_i && out_ready_i) begin
        if (snap_words_q.size() == 0) begin
          report("unexpected word, kind", out_data_i.counter_kind, 0);
        end else begin
          want = snap_words_q.pop_front();
          if (out_data_i.counter_kind !== want.counter_kind)
            report("counter_kind", out_data_i.counter_kind, want.counter_kind);
          if (out_data_i.counter_value !== want.counter_value)
            report("counter_value", out_data_i.counter_value, want.counter_value);
          if (out_data_i.last !== want.last)
            report("last", out_data_i.last, want.last);
        end
      end
      if (in_valid_i && in_ready_i) begin
        t = in_data_i.task_req;
        case (action_e'(in_data_i.action))
          ACT_RECORD: if (t < Tasks)
            account_cycle(t, in_data_i.scheduled_time, in_data_i.start_time,
                          in_data_i.finish_time);
          ACT_BEGIN: if (t < Tasks) begin
            pend_sched_q[t] = in_data_i.scheduled_time;
            pend_start_q[t] = in_data_i.start_time;
          end
          ACT_END: if (t < Tasks)
            account_cycle(t, pend_sched_q[t], pend_start_q[t], in_data_i.finish_time);
          ACT_EVENT: if (t < Tasks && in_data_i.event_kind < EventKinds)
            events_q[t][in_data_i.event_kind] = events_q[t][in_data_i.event_kind] + 1;
          ACT_STACK: if (t < Tasks) stack_q[t] = in_data_i.stack_words;
          ACT_SNAPSHOT: for (int k = 0; k < SnapWords; k++) begin
            w.counter_kind  = k;
            w.counter_value = (t < Tasks) ? counter_of(t, k) : '0;
            w.last          = (k == SnapWords - 1);
            snap_words_q.push_back(w);
          end
          ACT_CLEAR: wipe_counters();
          default: ;
        endcase
      end
      waiting_o = snap_words_q.size();
    end
  end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the task timing monitor: directed corner cases,
// then randomised task cycles, events and snapshots under several deadline
// settings, with random idling on both sides and a long sink stall.
// ----------------------------------------------------------------------------
module tb_top;
  import ttm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]       index;
    logic [WordW-1:0] value;
  } cfg_word_t;

  localparam int unsigned NumTasks  = 4;
  localparam int unsigned NumEvents = 2;
  localparam int unsigned StallLimit = 3000; // idle cycles before giving up
  localparam int unsigned LongHold   = 400;  // long sink stall, cycles

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  ttm_if #(.payload_t(in_word_t))  in_ch ();
  ttm_if #(.payload_t(cfg_word_t)) cfg_ch ();
  ttm_if #(.payload_t(out_word_t)) out_ch ();

  task_timing_monitor_core #(.Tasks(NumTasks), .EventKinds(NumEvents)) uut (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .in_ch (in_ch.sink), .cfg_ch (cfg_ch.sink), .out_ch (out_ch.source)
  );

  int unsigned errors;
  int unsigned waiting;

  ttm_checker #(.Tasks(NumTasks), .EventKinds(NumEvents)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid), .in_ready_i (in_ch.ready), .in_data_i (in_ch.data),
    .cfg_valid_i (cfg_ch.valid), .cfg_ready_i (cfg_ch.ready),
    .cfg_index_i (cfg_ch.data.index), .cfg_value_i (cfg_ch.data.value),
    .out_valid_i (out_ch.valid), .out_ready_i (out_ch.ready), .out_data_i (out_ch.data),
    .errors_o (errors), .waiting_o (waiting)
  );

  // idling control; burst flags switch idling off for a stretch
  bit send_burst;
  bit recv_burst;
  bit hold_sink;

  logic [TimeW-1:0] task_clock [NumTasks];

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  // ---- watchdog: cycles with no word moving on any channel ----
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
          (out_ch.valid && out_ch.ready) || !rst_ni)
        quiet = 0;
      else
        quiet++;
      if (quiet >= StallLimit) begin
        $display("task_timing_monitor_core: mismatch");
        $finish;
      end
    end
  end

  // ---- snapshot sink: random stalls per word, one long hold on request ----
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      gap = recv_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // ---- request driver: called at a falling edge, returns at one ----
  task automatic send_word(in_word_t w);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i); // record/end write back still in flight
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_deadline(logic [2:0] idx, logic [WordW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: val};
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_deadlines(logic [WordW-1:0] d0, logic [WordW-1:0] d1,
                               logic [WordW-1:0] d2, logic [WordW-1:0] d3);
    go_idle();
    write_deadline(0, d0);
    write_deadline(1, d1);
    write_deadline(2, d2);
    write_deadline(3, d3);
  endtask

  function automatic in_word_t mk(action_e a, logic [2:0] t, logic [TimeW-1:0] s,
                                  logic [TimeW-1:0] st, logic [TimeW-1:0] f);
    in_word_t w;
    w = '0;
    w.action = a; w.task_req = t;
    w.scheduled_time = s; w.start_time = st; w.finish_time = f;
    return w;
  endfunction

  function automatic logic [TimeW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // execution time near a histogram edge most of the time
  function automatic logic [TimeW-1:0] pick_exec();
    int unsigned edges[7] = '{100, 250, 500, 1000, 2500, 5000, 10000};
    case ($urandom_range(0, 9))
      0:       return 64'd1 << 32 + $urandom_range(0, 3);  // saturates
      1, 2:    return $urandom_range(0, 20000);
      default: return edges[$urandom_range(0, 6)] + $urandom_range(0, 2) - 1;
    endcase
  endfunction

  // one well formed task cycle, as a record or a begin/end pair
  task automatic task_cycle(logic [2:0] t);
    logic [TimeW-1:0] s;
    logic [TimeW-1:0] st;
    logic [TimeW-1:0] f;
    task_clock[t] = task_clock[t] + $urandom_range(0, 20000);
    s  = task_clock[t];
    st = ($urandom_range(0, 3) == 0) ? s - $urandom_range(0, 300) : s + $urandom_range(0, 3000);
    f  = ($urandom_range(0, 15) == 0) ? st - $urandom_range(1, 50) : st + pick_exec();
    if ($urandom_range(0, 1)) begin
      send_word(mk(ACT_RECORD, t, s, st, f));
    end else begin
      send_word(mk(ACT_BEGIN, t, s, st, rand64()));
      send_word(mk(ACT_END, t, rand64(), rand64(), f));
    end
  endtask

  task automatic misc_item();
    in_word_t w;
    logic [255:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = noise[$bits(in_word_t)-1:0];
    case ($urandom_range(0, 11))
      0, 1, 2: begin w.action = ACT_EVENT; w.task_req = $urandom_range(0, 4); end
      3:       begin w.action = ACT_STACK; w.task_req = $urandom_range(0, 4); end
      4, 5, 6: begin w.action = ACT_SNAPSHOT; w.task_req = $urandom_range(0, 4); end
      7:       w.action = ACT_CLEAR;
      default: ; // noise: any action, task or event code
    endcase
    send_word(w);
  endtask

  initial begin
    logic [TimeW-1:0] top;
    for (int t = 0; t < NumTasks; t++) task_clock[t] = $urandom;
    top = '1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed part ----
    set_deadlines(32'd150, 32'hFFFF_FFFF, 32'd0, 32'd1);
    write_deadline(3'd4, 32'hDEAD_BEEF); // out of range, dropped
    write_deadline(3'd7, 32'h1234_5678);
    cfg_ch.valid <= 1'b0;
    send_word(mk(ACT_END, 0, 0, 0, 64'd40));                 // end with no begin
    send_word(mk(ACT_RECORD, 0, 64'd1000, 64'd900, 64'd1200)); // early start
    send_word(mk(ACT_RECORD, 0, 0, top, top));               // huge gap
    send_word(mk(ACT_RECORD, 1, top, 0, top));               // saturated exec, jitter
    send_word(mk(ACT_RECORD, 1, 0, 64'd500, 64'd100));       // finish before start
    send_word(mk(ACT_BEGIN, 2, 64'd10, 64'd20, 0));
    send_word(mk(ACT_END, 2, 0, 0, 64'd10020));
    send_word(mk(ACT_RECORD, 3, 64'd5, 64'd5, 64'd7));       // misses by one
    begin
      in_word_t w;
      w = mk(ACT_EVENT, 1, 0, 0, 0);
      for (int e = 0; e < 8; e += 1) begin w.event_kind = 3'(e); send_word(w); end
      w = mk(ACT_STACK, 2, 0, 0, 0); w.stack_words = 32'hFFFF_FFFF; send_word(w);
      w.task_req = 6; send_word(w);                          // invalid task
      w = mk(action_e'(3'd7), 0, 0, 0, 0); send_word(w);     // unused code
    end
    for (int t = 0; t < 8; t += 2) send_word(mk(ACT_SNAPSHOT, t, 0, 0, 0));
    send_word(mk(ACT_SNAPSHOT, 1, 0, 0, 0));
    send_word(mk(ACT_SNAPSHOT, 3, 0, 0, 0));
    send_word(mk(ACT_CLEAR, 0, 0, 0, 0));
    send_word(mk(ACT_SNAPSHOT, 1, 0, 0, 0));

    // ---- long sink stall while requests keep coming ----
    hold_sink = 1'b1;
    send_word(mk(ACT_SNAPSHOT, 0, 0, 0, 0));
    task_cycle(0);
    send_word(mk(ACT_SNAPSHOT, 0, 0, 0, 0));
    go_idle();                                               // drain completely

    // ---- random part, deadline setting changed per phase ----
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_deadlines(0, 0, 0, 0);
        1: set_deadlines(32'hFFFF_FFFF, 32'd1, 32'd2500, 32'd100);
        2: set_deadlines($urandom_range(50, 12000), $urandom_range(50, 12000),
                         $urandom_range(50, 12000), $urandom_range(50, 12000));
        3: set_deadlines(32'd1, 32'd1, 32'hFFFF_FFFF, 0);
        default: set_deadlines($urandom, $urandom, $urandom, $urandom);
      endcase
      cfg_ch.valid <= 1'b0;
      for (int n = 0; n < 35; n++) begin
        if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
        if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
        if ($urandom_range(0, 2) != 0) task_cycle($urandom_range(0, NumTasks - 1));
        else misc_item();
      end
      send_word(mk(ACT_SNAPSHOT, $urandom_range(0, NumTasks - 1), 0, 0, 0));
    end

    // ---- drain and verdict ----
    in_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0)
      $display("task_timing_monitor_core: match");
    else
      $display("task_timing_monitor_core: mismatch");
    $finish;
  end

endmodule
